### design/mts_pkg.sv
package mts_pkg;

	// Status codes carried in the result
	localparam logic [2:0] STATUS_IDLE     = 3'd0;
	localparam logic [2:0] STATUS_WAITING  = 3'd1;
	localparam logic [2:0] STATUS_READY    = 3'd2;
	localparam logic [2:0] STATUS_RUNNING  = 3'd3;
	localparam logic [2:0] STATUS_FINISHED = 3'd4;
	localparam logic [2:0] STATUS_STOPPED  = 3'd5;

	// Configuration register indexes
	localparam logic [2:0] CFG_READY_THR  = 3'd0;
	localparam logic [2:0] CFG_START_THR  = 3'd1;
	localparam logic [2:0] CFG_STOP_THR   = 3'd2;
	localparam logic [2:0] CFG_LIMIT_MS   = 3'd3;
	localparam logic [2:0] CFG_START_HOLD = 3'd4;
	localparam logic [2:0] CFG_STOP_HOLD  = 3'd5;
	localparam logic [2:0] CFG_MIN_STEADY = 3'd6;

	// Configuration reset values
	localparam logic [12:0] RST_READY_THR  = 13'd80;
	localparam logic [12:0] RST_START_THR  = 13'd100;
	localparam logic [12:0] RST_STOP_THR   = 13'd275;
	localparam logic [31:0] RST_LIMIT_MS   = 32'd5000;
	localparam logic [5:0]  RST_START_HOLD = 6'd40;
	localparam logic [5:0]  RST_STOP_HOLD  = 6'd5;
	localparam logic [4:0]  RST_MIN_STEADY = 5'd13;

	// Steadiness counter limits
	localparam logic [4:0] STEADY_LIMIT = 5'd15;
	localparam logic [4:0] COUNT_TOP    = 5'd20;
	localparam logic [4:0] COUNT_BACK   = 5'd10;

	typedef struct packed {
		logic [12:0] ready_threshold;
		logic [12:0] start_threshold;
		logic [12:0] stop_threshold;
		logic [31:0] limit_ms;
		logic [5:0]  start_holdoff;
		logic [5:0]  stop_holdoff;
		logic [4:0]  min_steady;
	} mts_cfg_t;

	typedef struct packed {
		logic               operation;
		logic signed [12:0] accel_x;
		logic signed [12:0] accel_y;
		logic signed [12:0] accel_z;
		logic [31:0]        timestamp_ms;
	} mts_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        start_pulse;
		logic        stop_pulse;
		logic [31:0] elapsed_ms;
		logic        over_limit;
	} mts_result_t;

endpackage

### design/mts_cfg.sv
module mts_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_wdata,
	output mts_pkg::mts_cfg_t cfg
);

	mts_pkg::mts_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_threshold <= mts_pkg::RST_READY_THR;
			cfg_q.start_threshold <= mts_pkg::RST_START_THR;
			cfg_q.stop_threshold  <= mts_pkg::RST_STOP_THR;
			cfg_q.limit_ms        <= mts_pkg::RST_LIMIT_MS;
			cfg_q.start_holdoff   <= mts_pkg::RST_START_HOLD;
			cfg_q.stop_holdoff    <= mts_pkg::RST_STOP_HOLD;
			cfg_q.min_steady      <= mts_pkg::RST_MIN_STEADY;
		end else if (cfg_we) begin
			case (cfg_index)
				mts_pkg::CFG_READY_THR:  cfg_q.ready_threshold <= cfg_wdata[12:0];
				mts_pkg::CFG_START_THR:  cfg_q.start_threshold <= cfg_wdata[12:0];
				mts_pkg::CFG_STOP_THR:   cfg_q.stop_threshold  <= cfg_wdata[12:0];
				mts_pkg::CFG_LIMIT_MS:   cfg_q.limit_ms        <= cfg_wdata;
				mts_pkg::CFG_START_HOLD: cfg_q.start_holdoff   <= cfg_wdata[5:0];
				mts_pkg::CFG_STOP_HOLD:  cfg_q.stop_holdoff    <= cfg_wdata[5:0];
				mts_pkg::CFG_MIN_STEADY: cfg_q.min_steady      <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/mts_engine.sv
module mts_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mts_pkg::mts_cfg_t    cfg,
	input  logic                 fire,
	input  mts_pkg::mts_item_t   item,
	output mts_pkg::mts_result_t result
);

	function automatic logic [12:0] absdiff13(input logic signed [12:0] a,
			input logic signed [12:0] b);
		logic signed [13:0] d;
		logic [13:0] n;
		d = 14'(a) - 14'(b);
		n = -d;
		return d[13] ? n[12:0] : d[12:0];
	endfunction

	logic signed [12:0] prev_x_q, prev_y_q, prev_z_q;
	logic               prev_valid_q;
	logic [4:0]         steady_q;
	logic               timing_q;
	logic [5:0]         holdoff_q;
	logic [31:0]        start_time_q;
	logic [31:0]        elapsed_q;
	logic               over_q;
	logic [2:0]         status_q;
	logic               enabled_q;

	logic               store;
	logic [4:0]         steady_d;
	logic               timing_d;
	logic [5:0]         holdoff_d;
	logic [31:0]        start_time_d;
	logic [31:0]        elapsed_d;
	logic               over_d;
	logic [2:0]         status_d;
	logic               enabled_d;
	logic               spulse, epulse;

	logic [12:0] dx, dy, dz;
	logic [4:0]  cnt_inc;
	logic [31:0] interval;
	logic        any_move, all_start, all_stop;

	assign dx = absdiff13(prev_x_q, item.accel_x);
	assign dy = absdiff13(prev_y_q, item.accel_y);
	assign dz = absdiff13(prev_z_q, item.accel_z);

	assign any_move  = (dx > cfg.ready_threshold) || (dy > cfg.ready_threshold) ||
		(dz > cfg.ready_threshold);
	assign all_start = (dx >= cfg.start_threshold) && (dy >= cfg.start_threshold) &&
		(dz >= cfg.start_threshold);
	assign all_stop  = (dx > cfg.stop_threshold) && (dy > cfg.stop_threshold) &&
		(dz > cfg.stop_threshold);
	assign cnt_inc   = steady_q + 5'd1;
	assign interval  = item.timestamp_ms - start_time_q;

	always_comb begin
		store        = 1'b0;
		steady_d     = steady_q;
		timing_d     = timing_q;
		holdoff_d    = holdoff_q;
		start_time_d = start_time_q;
		elapsed_d    = elapsed_q;
		over_d       = over_q;
		status_d     = status_q;
		enabled_d    = enabled_q;
		spulse       = 1'b0;
		epulse       = 1'b0;
		if (item.operation) begin
			if (enabled_q) begin
				enabled_d = 1'b0;
				status_d  = mts_pkg::STATUS_STOPPED;
			end else begin
				enabled_d = 1'b1;
				status_d  = mts_pkg::STATUS_IDLE;
				steady_d  = '0;
			end
		end else if (enabled_q) begin
			if (holdoff_q != '0) begin
				holdoff_d = holdoff_q - 6'd1;
				store     = 1'b1;
			end else if (!prev_valid_q && !timing_q) begin
				store = 1'b1;
			end else if (!timing_q) begin
				if (steady_q < mts_pkg::STEADY_LIMIT && any_move) begin
					status_d = mts_pkg::STATUS_WAITING;
					steady_d = '0;
					store    = 1'b1;
				end else if (cnt_inc >= cfg.min_steady && all_start) begin
					start_time_d = item.timestamp_ms;
					spulse       = 1'b1;
					steady_d     = '0;
					timing_d     = 1'b1;
					holdoff_d    = cfg.start_holdoff;
					status_d     = mts_pkg::STATUS_RUNNING;
					store        = 1'b1;
				end else if (cnt_inc >= mts_pkg::COUNT_TOP) begin
					// wrap the counter back and keep the old reference sample
					status_d = mts_pkg::STATUS_READY;
					steady_d = mts_pkg::COUNT_BACK;
				end else begin
					status_d = mts_pkg::STATUS_READY;
					steady_d = cnt_inc;
					store    = 1'b1;
				end
			end else begin
				if (all_stop) begin
					timing_d  = 1'b0;
					steady_d  = '0;
					holdoff_d = cfg.stop_holdoff;
					status_d  = mts_pkg::STATUS_FINISHED;
					epulse    = 1'b1;
					elapsed_d = interval;
					over_d    = interval > cfg.limit_ms;
				end
				store = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			prev_valid_q <= 1'b0;
			steady_q     <= '0;
			timing_q     <= 1'b0;
			holdoff_q    <= '0;
			start_time_q <= '0;
			elapsed_q    <= '0;
			over_q       <= 1'b0;
			status_q     <= mts_pkg::STATUS_IDLE;
			enabled_q    <= 1'b1;
		end else if (fire) begin
			if (store) begin
				prev_x_q     <= item.accel_x;
				prev_y_q     <= item.accel_y;
				prev_z_q     <= item.accel_z;
				prev_valid_q <= 1'b1;
			end
			steady_q     <= steady_d;
			timing_q     <= timing_d;
			holdoff_q    <= holdoff_d;
			start_time_q <= start_time_d;
			elapsed_q    <= elapsed_d;
			over_q       <= over_d;
			status_q     <= status_d;
			enabled_q    <= enabled_d;
		end
	end

	assign result.status      = status_d;
	assign result.start_pulse = spulse;
	assign result.stop_pulse  = epulse;
	assign result.elapsed_ms  = elapsed_d;
	assign result.over_limit  = over_d;

endmodule

### design/motion_triggered_stopwatch_core.sv
// Motion-triggered stopwatch core.
//
// Input stream (s_*): one request per accelerometer sample or button press.
// s_tuser selects the kind: 0 sample, 1 button press. s_tdata carries the
// three signed 13-bit axes and the 32-bit sample timestamp.
// Output stream (m_*): exactly one result per request, in request order:
// status, start and stop pulses, last elapsed milliseconds and over-limit flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// write only while no request is in flight.
// Order: an accepted request is registered in the input stage, and its result is
// loaded into the result register when that register is empty or being drained.
// Throughput: one request per cycle while m_tready is high; the whole update is
// a single pass of compare and subtract logic from input stage to result register.
// Reset: arst_n clears the pipeline, restores register defaults, the stopwatch
// state goes idle with sample processing enabled.
// Stall: while a result waits and m_tready is low the result register holds its value; one more
// request is taken into the input stage, after which s_tready drops.
module motion_triggered_stopwatch_core (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	// [12:0] accel_x, [25:13] accel_y, [38:26] accel_z, [70:39] timestamp_ms,
	// [71] zero
	input  logic [71:0] s_tdata,
	// [0] operation
	input  logic        s_tuser,
	// Result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] status, [3] start_pulse, [4] stop_pulse, [36:5] elapsed_ms,
	// [37] over_limit, [39:38] zero
	output logic [39:0] m_tdata,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	mts_pkg::mts_cfg_t    cfg;
	mts_pkg::mts_item_t   item_s1;
	logic                 valid_s1;
	mts_pkg::mts_result_t result;
	mts_pkg::mts_result_t out_q;
	logic                 out_valid_q;
	logic                 advance;
	logic                 fire;

	// The result register may load when empty or being drained
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	mts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Input stage: hold the request until the engine consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation    <= s_tuser;
			item_s1.accel_x      <= s_tdata[12:0];
			item_s1.accel_y      <= s_tdata[25:13];
			item_s1.accel_z      <= s_tdata[38:26];
			item_s1.timestamp_ms <= s_tdata[70:39];
		end
	end

	mts_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	// Result register: load on fire, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.over_limit, out_q.elapsed_ms, out_q.stop_pulse,
		out_q.start_pulse, out_q.status};

endmodule

### design/mts_checker.sv
module mts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Back-pressure only while a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("request channel stalled without a waiting result");

	// Start and stop never fall on the same request
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
		else $error("start and stop pulse together");

	// A start pulse reports running
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == mts_pkg::STATUS_RUNNING)
		else $error("start pulse without running status");

	// A stop pulse reports finished
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[2:0] == mts_pkg::STATUS_FINISHED)
		else $error("stop pulse without finished status");

endmodule

bind motion_triggered_stopwatch_core mts_checker u_mts_checker (.*);

### test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Request kinds carried on s_tuser
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_BUTTON = 1'b1;

	// Cycles with no handshake on either side before the run is abandoned
	localparam int STALL_LIMIT = 500;

	// Mirror of the stopwatch: its registers, its state and the reports it owes
	class stopwatch_scoreboard;
		mts_pkg::mts_cfg_t    cfg;
		logic signed [12:0]   last_x, last_y, last_z;
		logic                 have_last;
		logic                 timing;
		logic                 enabled;
		logic [4:0]           steady;
		logic [5:0]           holdoff;
		logic [31:0]          start_time;
		logic [31:0]          last_elapsed;
		logic                 last_over;
		logic [2:0]           status;
		mts_pkg::mts_result_t due_reports[$];
		int                   errors;

		function new();
			cfg = '{mts_pkg::RST_READY_THR, mts_pkg::RST_START_THR,
				mts_pkg::RST_STOP_THR, mts_pkg::RST_LIMIT_MS, mts_pkg::RST_START_HOLD,
				mts_pkg::RST_STOP_HOLD, mts_pkg::RST_MIN_STEADY};
			last_x = '0;
			last_y = '0;
			last_z = '0;
			have_last = 1'b0;
			timing = 1'b0;
			enabled = 1'b1;
			steady = '0;
			holdoff = '0;
			start_time = '0;
			last_elapsed = '0;
			last_over = 1'b0;
			status = mts_pkg::STATUS_IDLE;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				mts_pkg::CFG_READY_THR:  cfg.ready_threshold = val[12:0];
				mts_pkg::CFG_START_THR:  cfg.start_threshold = val[12:0];
				mts_pkg::CFG_STOP_THR:   cfg.stop_threshold = val[12:0];
				mts_pkg::CFG_LIMIT_MS:   cfg.limit_ms = val;
				mts_pkg::CFG_START_HOLD: cfg.start_holdoff = val[5:0];
				mts_pkg::CFG_STOP_HOLD:  cfg.stop_holdoff = val[5:0];
				mts_pkg::CFG_MIN_STEADY: cfg.min_steady = val[4:0];
				default: ;
			endcase
		endfunction

		function int unsigned axis_change(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void advance_stopwatch(input mts_pkg::mts_item_t it, output logic sp,
				output logic ep);
			int unsigned dx, dy, dz;
			bit          keep;
			sp = 1'b0;
			ep = 1'b0;
			keep = 1'b1;
			dx = axis_change(last_x, $signed(it.accel_x));
			dy = axis_change(last_y, $signed(it.accel_y));
			dz = axis_change(last_z, $signed(it.accel_z));
			if (holdoff != 0) begin
				holdoff = holdoff - 1'b1;
			end else if (!have_last && !timing) begin
				// first sample only seeds the comparison
			end else if (!timing) begin
				if (steady < mts_pkg::STEADY_LIMIT && (dx > cfg.ready_threshold ||
						dy > cfg.ready_threshold || dz > cfg.ready_threshold)) begin
					status = mts_pkg::STATUS_WAITING;
					steady = '0;
				end else begin
					status = mts_pkg::STATUS_READY;
					steady = steady + 1'b1;
					if (steady >= cfg.min_steady && dx >= cfg.start_threshold &&
							dy >= cfg.start_threshold && dz >= cfg.start_threshold) begin
						start_time = it.timestamp_ms;
						sp = 1'b1;
						steady = '0;
						timing = 1'b1;
						holdoff = cfg.start_holdoff;
						status = mts_pkg::STATUS_RUNNING;
					end else if (steady >= mts_pkg::COUNT_TOP) begin
						// counter folds back and the old sample stays as reference
						steady = mts_pkg::COUNT_BACK;
						keep = 1'b0;
					end
				end
			end else if (dx > cfg.stop_threshold && dy > cfg.stop_threshold &&
					dz > cfg.stop_threshold) begin
				timing = 1'b0;
				steady = '0;
				holdoff = cfg.stop_holdoff;
				status = mts_pkg::STATUS_FINISHED;
				ep = 1'b1;
				last_elapsed = it.timestamp_ms - start_time;
				last_over = last_elapsed > cfg.limit_ms;
			end
			if (keep) begin
				last_x = it.accel_x;
				last_y = it.accel_y;
				last_z = it.accel_z;
				have_last = 1'b1;
			end
		endfunction

		function void note_request(mts_pkg::mts_item_t it);
			mts_pkg::mts_result_t r;
			logic                 sp, ep;
			sp = 1'b0;
			ep = 1'b0;
			if (it.operation == OP_BUTTON) begin
				if (enabled) begin
					enabled = 1'b0;
					status = mts_pkg::STATUS_STOPPED;
				end else begin
					enabled = 1'b1;
					status = mts_pkg::STATUS_IDLE;
					steady = '0;
				end
			end else if (enabled) begin
				advance_stopwatch(it, sp, ep);
			end
			r.status = status;
			r.start_pulse = sp;
			r.stop_pulse = ep;
			r.elapsed_ms = last_elapsed;
			r.over_limit = last_over;
			due_reports.push_back(r);
		endfunction

		function void check_result(logic [39:0] word);
			mts_pkg::mts_result_t want, got;
			got.status = word[2:0];
			got.start_pulse = word[3];
			got.stop_pulse = word[4];
			got.elapsed_ms = word[36:5];
			got.over_limit = word[37];
			if (due_reports.size() == 0) begin
				$error("result %h arrived with no request outstanding", word);
				errors++;
			end else begin
				want = due_reports.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					errors++;
				end
				if (got.start_pulse !== want.start_pulse) begin
					$error("start_pulse: expected %0d, actual %0d", want.start_pulse,
						got.start_pulse);
					errors++;
				end
				if (got.stop_pulse !== want.stop_pulse) begin
					$error("stop_pulse: expected %0d, actual %0d", want.stop_pulse,
						got.stop_pulse);
					errors++;
				end
				if (got.elapsed_ms !== want.elapsed_ms) begin
					$error("elapsed_ms: expected %0d, actual %0d", want.elapsed_ms,
						got.elapsed_ms);
					errors++;
				end
				if (got.over_limit !== want.over_limit) begin
					$error("over_limit: expected %0d, actual %0d", want.over_limit,
						got.over_limit);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due_reports.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	stopwatch_scoreboard sb = new();

	// Stimulus pacing: tx_calm and rx_calm open stretches with no idling,
	// no_idle shuts idling off for the closing part of the run
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit no_idle = 1'b0;
	int stall_left = 0;

	// Running position of the synthetic arm, so that steady samples stay close
	int          gx = 0, gy = 0, gz = 0;
	logic [31:0] gts = '0;

	motion_triggered_stopwatch_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic mts_pkg::mts_item_t mk(logic op, int x, int y, int z,
			logic [31:0] ts);
		mts_pkg::mts_item_t it;
		it.operation = op;
		it.accel_x = x[12:0];
		it.accel_y = y[12:0];
		it.accel_z = z[12:0];
		it.timestamp_ms = ts;
		return it;
	endfunction

	function automatic int clamp13(int v);
		return (v > 4095) ? 4095 : (v < -4096) ? -4096 : v;
	endfunction

	// Throw an axis towards the far rail; a zero offset lands exactly on it
	function automatic int jolt_axis(int v);
		int r;
		r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3000);
		return (v < 0) ? 4095 - r : -4096 + r;
	endfunction

	// Next random request: mostly steady drift and jolts so that the arm
	// actually reaches ready, running and finished; some noise and buttons
	function automatic mts_pkg::mts_item_t next_item();
		int pick, s;
		pick = $urandom_range(0, 99);
		gts = ($urandom_range(0, 19) == 0) ? $urandom : gts + $urandom_range(0, 300);
		if (sb.enabled ? pick < 3 : pick < 50) begin
			return mk(OP_BUTTON, $urandom_range(0, 8191), $urandom_range(0, 8191),
				$urandom_range(0, 8191), $urandom);
		end
		if (!sb.enabled || pick >= 88) begin
			gx = int'($urandom_range(0, 8191)) - 4096;
			gy = int'($urandom_range(0, 8191)) - 4096;
			gz = int'($urandom_range(0, 8191)) - 4096;
		end else if (pick < 68) begin
			case ($urandom_range(0, 3))
				0: s = 0;
				1: s = 6;
				2: s = 40;
				default: s = 150;
			endcase
			gx = clamp13(gx + int'($urandom_range(0, 2 * s)) - s);
			gy = clamp13(gy + int'($urandom_range(0, 2 * s)) - s);
			gz = clamp13(gz + int'($urandom_range(0, 2 * s)) - s);
		end else begin
			gx = jolt_axis(gx);
			gy = jolt_axis(gy);
			gz = jolt_axis(gz);
		end
		return mk(OP_SAMPLE, gx, gy, gz, gts);
	endfunction

	// Offer one request, optionally after a short gap, and hold it until taken;
	// valid stays high afterwards so back-to-back requests need no re-raise
	task automatic send(input mts_pkg::mts_item_t it, input bit may_idle);
		int pause;
		if (may_idle && $urandom_range(0, 5) == 0) begin
			pause = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.operation;
		s_tdata <= {1'b0, it.timestamp_ms, it.accel_z, it.accel_y, it.accel_x};
		do @(posedge clk); while (!s_tready);
		sb.note_request(it);
	endtask

	// Drop valid and wait for every outstanding report to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Write all seven registers back to back; only called with the block idle
	task automatic apply_settings(input mts_pkg::mts_cfg_t c);
		put_reg(mts_pkg::CFG_READY_THR, 32'(c.ready_threshold));
		put_reg(mts_pkg::CFG_START_THR, 32'(c.start_threshold));
		put_reg(mts_pkg::CFG_STOP_THR, 32'(c.stop_threshold));
		put_reg(mts_pkg::CFG_LIMIT_MS, c.limit_ms);
		put_reg(mts_pkg::CFG_START_HOLD, 32'(c.start_holdoff));
		put_reg(mts_pkg::CFG_STOP_HOLD, 32'(c.stop_holdoff));
		put_reg(mts_pkg::CFG_MIN_STEADY, 32'(c.min_steady));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One settings phase: only requests the block acts on count towards n
	task automatic run_phase(input mts_pkg::mts_cfg_t c, input int n, input bit quiet);
		int                 done;
		mts_pkg::mts_item_t it;
		apply_settings(c);
		no_idle = quiet;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
			it = next_item();
			if (it.operation == OP_BUTTON || sb.enabled) done++;
			send(it, !(quiet || tx_calm));
		end
		drain();
	endtask

	// Result side: random stall bursts, with calm stretches
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!no_idle && !rx_calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check every report as it is taken
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Abandon the run when neither side moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		mts_pkg::mts_cfg_t c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short hold-offs, a low steadiness bar and no change counted as
		// movement keep the directed walk brief
		c = '{13'h1FFF, mts_pkg::RST_START_THR, mts_pkg::RST_STOP_THR,
			mts_pkg::RST_LIMIT_MS, 6'd1, 6'd1, 5'd2};
		apply_settings(c);
		// disable, ignored sample, enable again
		send(mk(OP_BUTTON, 0, 0, 0, 32'd0), 1'b1);
		send(mk(OP_SAMPLE, 100, 100, 100, 32'd1), 1'b1);
		send(mk(OP_BUTTON, -4096, 4095, -1, 32'hFFFF_FFFF), 1'b1);
		// first sample at the lower rail, then a full-scale move
		send(mk(OP_SAMPLE, -4096, -4096, -4096, 32'hFFFF_FFF0), 1'b1);
		send(mk(OP_SAMPLE, 4095, 4095, 4095, 32'hFFFF_FFF1), 1'b1);
		send(mk(OP_SAMPLE, 4095, 4095, 4095, 32'hFFFF_FFF2), 1'b1);
		send(mk(OP_SAMPLE, 4090, 4095, 4095, 32'hFFFF_FFF3), 1'b1);
		// start at the top of the timestamp range, stop after it wraps
		send(mk(OP_SAMPLE, -4096, -4096, -4096, 32'hFFFF_FFFF), 1'b1);
		send(mk(OP_SAMPLE, 0, 0, 0, 32'd0), 1'b1);
		send(mk(OP_SAMPLE, 300, -300, 276, 32'h20), 1'b1);
		send(mk(OP_SAMPLE, 0, 0, 0, 32'h21), 1'b1);
		send(mk(OP_SAMPLE, 0, 0, 0, 32'h22), 1'b1);
		send(mk(OP_SAMPLE, 0, 0, 0, 32'h23), 1'b1);
		// start on a change exactly at the start threshold
		send(mk(OP_SAMPLE, 100, -100, 100, 32'd6000), 1'b1);
		send(mk(OP_SAMPLE, 100, -100, 100, 32'd6001), 1'b1);
		// toggle off and on while timing; the timer must survive it
		send(mk(OP_BUTTON, 0, 0, 0, 32'd6002), 1'b1);
		send(mk(OP_SAMPLE, -4096, 4095, -4096, 32'd6003), 1'b1);
		send(mk(OP_BUTTON, 0, 0, 0, 32'd6004), 1'b1);
		// a change equal to the stop threshold does not stop; a larger one does
		send(mk(OP_SAMPLE, 375, -375, 375, 32'd20000), 1'b1);
		send(mk(OP_SAMPLE, -4096, 4095, -4096, 32'd30000), 1'b1);
		send(mk(OP_SAMPLE, 0, 0, 0, 32'd30001), 1'b1);
		drain();

		// Reset values, then the low and high extremes of every register
		c = '{mts_pkg::RST_READY_THR, mts_pkg::RST_START_THR, mts_pkg::RST_STOP_THR,
			mts_pkg::RST_LIMIT_MS, mts_pkg::RST_START_HOLD, mts_pkg::RST_STOP_HOLD,
			mts_pkg::RST_MIN_STEADY};
		run_phase(c, 190, 1'b0);
		c = '{13'd0, 13'd0, 13'd0, 32'd0, 6'd0, 6'd0, 5'd0};
		run_phase(c, 190, 1'b0);
		c = '{13'h1FFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF, 6'd63, 6'd63, 5'd20};
		run_phase(c, 190, 1'b0);
		// steadiness bar beyond the counter's reach: timing can never start
		c = '{13'd100, 13'd200, 13'd400, 32'd0, 6'd3, 6'd2, 5'd31};
		run_phase(c, 120, 1'b0);
		// random moderate settings; the last phase runs with no idling at all
		for (int p = 0; p < 3; p++) begin
			c.ready_threshold = 13'($urandom_range(0, 300));
			c.start_threshold = 13'($urandom_range(0, 1500));
			c.stop_threshold = 13'($urandom_range(0, 3000));
			c.limit_ms = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20000);
			c.start_holdoff = 6'($urandom_range(0, 8));
			c.stop_holdoff = 6'($urandom_range(0, 8));
			c.min_steady = 5'($urandom_range(0, 20));
			run_phase(c, 190, p == 2);
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
